>>> rtl/assert_macros.svh
// Assertion helper macros shared by the RTL that carries checks.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Hold cons whenever ante holds on the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Hold cons on the edge after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fln2a_pkg.sv
// Shared types, constants and helpers for the number-to-ASCII formatter.
// No dependencies.
package fln2a_pkg;

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_BIN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIGIT
  } state_e;

  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned DEC_WORD_W = 4 * DEC_DIGITS;

  // Digit positions available in each mode, as 7-bit position values
  localparam logic [6:0] NATIVE_DEC = 7'd10;
  localparam logic [6:0] NATIVE_HEX = 7'd8;
  localparam logic [6:0] NATIVE_BIN = 7'd32;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = CHAR_ZERO + {3'b000, d};
    end else begin
      ch = CHAR_A + {3'b000, d} - 7'd10;
    end
    return ch;
  endfunction

endpackage

>>> rtl/fln2a_div10.sv
// Iterative divide-by-ten unit: peels ten decimal digits off a 32-bit value.
// Depends on fln2a_pkg. Each digit takes a multiply step, then a subtract step.
module fln2a_div10 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [31:0]                       value_i,
  output logic                              busy_o,
  output logic [fln2a_pkg::DEC_WORD_W-1:0]  digits_o
);

  localparam logic [3:0] LAST_STEP = 4'(fln2a_pkg::DEC_DIGITS - 1);

  logic        busy_q, busy_d;
  logic        phase_q, phase_d;
  logic [3:0]  step_q, step_d;
  logic [31:0] value_q;
  logic [63:0] prod_q;
  logic [fln2a_pkg::DEC_WORD_W-1:0] digits_q;
  logic [31:0] quot;
  logic [31:0] rem;

  always_comb begin
    quot = 32'(prod_q[63:fln2a_pkg::RECIP_SHIFT]);
    rem  = value_q - {quot[28:0], 3'b000} - {quot[30:0], 1'b0};
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    step_d  = step_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      step_d  = '0;
    end else if (busy_q) begin
      phase_d = ~phase_q;
      if (phase_q) begin
        step_d = step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      step_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  // Digits enter at the top, so the least significant one ends at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q <= value_i;
    end else if (busy_q && !phase_q) begin
      prod_q <= {32'b0, value_q} * {32'b0, fln2a_pkg::RECIP_10};
    end else if (busy_q && phase_q) begin
      value_q  <= quot;
      digits_q <= {rem[3:0], digits_q[fln2a_pkg::DEC_WORD_W-1:4]};
    end
  end

  assign busy_o   = busy_q;
  assign digits_o = digits_q;

endmodule

>>> rtl/fixed_length_number_to_ascii.sv
// Hex and binary modes with a nonzero count go from idle straight to the digit state;
// decimal modes first run digit extraction (ten digits on the divide-by-ten unit, each a
// multiply step and then a subtract step) and then hand over to the sign or digit state,
// or back to idle in unsigned mode with a zero count. Sequential: a new number is accepted
// only when the sequencer is back in idle, and a stalled output port holds the sequencer.
// Reset clears the sequencer, divide-unit control and output valid flag only; no memory is cleared.
// Depends on fln2a_pkg, fln2a_div10 and assert_macros.svh.
`include "assert_macros.svh"

module fixed_length_number_to_ascii #(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] number_i,
  input  logic [5:0]  digit_count_i,
  input  logic [2:0]  start_line_i,
  input  logic [4:0]  start_column_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_code_o,
  output logic [2:0]  out_line_o,
  output logic [5:0]  out_column_o,
  output logic        last_o
);

  // Count width: wide enough to hold MAX_DIGITS itself
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  fln2a_pkg::state_e state_q, state_d;

  // Per-transaction context, loaded on input accept
  fln2a_pkg::mode_e mode_q;
  logic [31:0]      mag_q;
  logic             neg_q;
  logic [CW-1:0]    pos_q;
  logic [2:0]       line_q;
  logic [5:0]       col_q;

  // Output register
  logic       out_valid_q;
  logic [6:0] char_q;
  logic [2:0] oline_q;
  logic [5:0] ocol_q;
  logic       last_q;

  logic          in_fire;
  logic          is_dec_in;
  logic          neg_in;
  logic [31:0]   mag_in;
  logic [CW-1:0] count_sat;
  logic          div_start;
  logic          div_busy;
  logic [fln2a_pkg::DEC_WORD_W-1:0] dec_word;
  logic          out_free;
  logic          emit;
  logic [6:0]    emit_char;
  logic          emit_last;
  logic [CW-1:0] p;
  logic [6:0]    p7;
  logic [3:0]    dsel;

  // Magnitude: negate a negative value in signed mode (most negative wraps to 2^31)
  assign neg_in    = (command_i == fln2a_pkg::MODE_SDEC) && number_i[31];
  assign mag_in    = neg_in ? (32'd0 - number_i) : number_i;
  assign is_dec_in = (command_i == fln2a_pkg::MODE_UDEC) || (command_i == fln2a_pkg::MODE_SDEC);
  assign count_sat = ({1'b0, digit_count_i} > 7'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                              : CW'(digit_count_i);

  assign in_ready_o = (state_q == fln2a_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign div_start  = in_fire && is_dec_in;
  assign out_free   = !out_valid_q || out_ready_i;

  fln2a_div10 u_div10 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .value_i  (mag_in),
    .busy_o   (div_busy),
    .digits_o (dec_word)
  );

  // Digit position being shown, counted from the least significant digit.
  // Positions past the native width of the mode read as zero.
  always_comb begin
    p    = pos_q - CW'(1);
    p7   = 7'(p);
    dsel = 4'd0;
    unique case (mode_q)
      fln2a_pkg::MODE_HEX: begin
        if (p7 < fln2a_pkg::NATIVE_HEX) begin
          dsel = 4'(mag_q >> {p7[2:0], 2'b00});
        end
      end
      fln2a_pkg::MODE_BIN: begin
        if (p7 < fln2a_pkg::NATIVE_BIN) begin
          dsel = {3'b000, mag_q[p7[4:0]]};
        end
      end
      fln2a_pkg::MODE_UDEC, fln2a_pkg::MODE_SDEC: begin
        if (p7 < fln2a_pkg::NATIVE_DEC) begin
          dsel = 4'(dec_word >> {p7[3:0], 2'b00});
        end
      end
      default: dsel = 4'd0;
    endcase
  end

  // Sequencer: idle -> (extract digits) -> (sign) -> (digits) -> idle
  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    emit_char = fln2a_pkg::CHAR_ZERO;
    emit_last = 1'b0;
    unique case (state_q)
      fln2a_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (is_dec_in) begin
            state_d = fln2a_pkg::S_DIV;
          end else if (count_sat != '0) begin
            state_d = fln2a_pkg::S_DIGIT;
          end
        end
      end
      fln2a_pkg::S_DIV: begin
        if (!div_busy) begin
          if (mode_q == fln2a_pkg::MODE_SDEC) begin
            state_d = fln2a_pkg::S_SIGN;
          end else if (pos_q != '0) begin
            state_d = fln2a_pkg::S_DIGIT;
          end else begin
            state_d = fln2a_pkg::S_IDLE;
          end
        end
      end
      fln2a_pkg::S_SIGN: begin
        emit_char = neg_q ? fln2a_pkg::CHAR_MINUS : fln2a_pkg::CHAR_PLUS;
        emit_last = (pos_q == '0);
        if (out_free) begin
          emit    = 1'b1;
          state_d = emit_last ? fln2a_pkg::S_IDLE : fln2a_pkg::S_DIGIT;
        end
      end
      fln2a_pkg::S_DIGIT: begin
        emit_char = fln2a_pkg::digit_char(dsel);
        emit_last = (pos_q == CW'(1));
        if (out_free) begin
          emit = 1'b1;
          if (emit_last) begin
            state_d = fln2a_pkg::S_IDLE;
          end
        end
      end
      default: state_d = fln2a_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fln2a_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Context and output payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= fln2a_pkg::mode_e'(command_i);
      mag_q  <= mag_in;
      neg_q  <= neg_in;
      pos_q  <= count_sat;
      line_q <= start_line_i;
      col_q  <= {1'b0, start_column_i};
    end else if (emit) begin
      col_q <= col_q + 6'd1;
      if (state_q == fln2a_pkg::S_DIGIT) begin
        pos_q <= pos_q - CW'(1);
      end
    end
    if (emit) begin
      char_q  <= emit_char;
      oline_q <= line_q;
      ocol_q  <= col_q;
      last_q  <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign out_line_o   = oline_q;
  assign out_column_o = ocol_q;
  assign last_o       = last_q;

  // A character that is not the last means the run is still being produced
  `ASSERT_IMPLIES(a_run_open, out_valid_o && out_ready_i && !last_o, state_q == fln2a_pkg::S_SIGN || state_q == fln2a_pkg::S_DIGIT, "non-final character with sequencer idle")
  // The divide unit only runs while the sequencer waits for it
  `ASSERT_IMPLIES(a_div_idle, in_ready_o, !div_busy, "divide unit busy while idle")
  // The digit state always has at least one digit left
  `ASSERT_ALWAYS(a_pos_nonzero, state_q != fln2a_pkg::S_DIGIT || pos_q != '0, "digit state with no digits left")
  // Characters of one run follow back to back at consecutive columns
  `ASSERT_NEXT(a_col_step, out_valid_o && out_ready_i && !last_o, out_valid_o && out_column_o == $past(out_column_o) + 6'd1, "column did not advance by one")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for fixed_length_number_to_ascii: drives numbers through the
// valid/ready input port and checks every emitted character against a local formatter.
// Depends on fln2a_pkg and on the RTL of fixed_length_number_to_ascii.
module testbench;

  localparam int unsigned MAX_COUNT   = 32;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned RANDOM_ITEMS = 88;
  localparam int unsigned DRAIN_CYCLES = 64;

  // One emitted character as the block should present it
  typedef struct {
    logic [6:0] code;
    logic [2:0] line;
    logic [5:0] column;
    logic       last;
  } glyph_t;

  // Holds the characters still owed by the block, oldest first, and
  // counts every mismatch found against them.
  class char_scoreboard;
    glyph_t      expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Format one accepted number and queue the characters it should produce
    function void note_number(fln2a_pkg::mode_e mode, logic [31:0] number, logic [5:0] count,
                              logic [2:0] line, logic [4:0] column);
      logic [31:0] magnitude;
      logic [31:0] rest;
      logic [3:0]  dec_digit [10];
      logic [3:0]  d;
      logic [5:0]  n;
      int unsigned pos;
      int unsigned k;
      glyph_t      g;
      magnitude = number;
      n = (count > MAX_COUNT) ? 6'(MAX_COUNT) : count;
      k = 0;
      g.line = line;
      if (mode == fln2a_pkg::MODE_SDEC) begin
        if (number[31]) magnitude = -number;
        g.code   = number[31] ? fln2a_pkg::CHAR_MINUS : fln2a_pkg::CHAR_PLUS;
        g.column = {1'b0, column};
        g.last   = (n == 0);
        expected_q.push_back(g);
        k = 1;
      end
      rest = magnitude;
      for (int i = 0; i < 10; i++) begin
        dec_digit[i] = 4'(rest % 10);
        rest = rest / 10;
      end
      for (int i = 0; i < n; i++) begin
        pos = n - 1 - i;
        case (mode)
          fln2a_pkg::MODE_HEX: d = (pos < 8) ? magnitude[pos*4 +: 4] : 4'd0;
          fln2a_pkg::MODE_BIN: d = (pos < 32) ? {3'b000, magnitude[pos]} : 4'd0;
          default:             d = (pos < 10) ? dec_digit[pos] : 4'd0;
        endcase
        g.code   = (d < 10) ? fln2a_pkg::CHAR_ZERO + 7'(d)
                            : fln2a_pkg::CHAR_A + 7'(d) - 7'd10;
        g.column = {1'b0, column} + 6'(k);
        g.last   = (i == n - 1);
        expected_q.push_back(g);
        k++;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted character with the oldest one owed
    task check_char(logic [6:0] code, logic [2:0] line, logic [5:0] column, logic last);
      glyph_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h line %0d column %0d",
                                  code, line, column));
        return;
      end
      want = expected_q.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("char_code 0x%02h, want 0x%02h", code, want.code));
      if (line !== want.line)
        report_mismatch($sformatf("out_line %0d, want %0d", line, want.line));
      if (column !== want.column)
        report_mismatch($sformatf("out_column %0d, want %0d", column, want.column));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [31:0] number_i;
  logic [5:0]  digit_count_i;
  logic [2:0]  start_line_i;
  logic [4:0]  start_column_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [6:0]  char_code_o;
  logic [2:0]  out_line_o;
  logic [5:0]  out_column_o;
  logic        last_o;

  // Set while both sides must run without any idle cycle
  logic steady;

  char_scoreboard digits_sb = new();

  fixed_length_number_to_ascii #(
    .MAX_DIGITS(MAX_COUNT)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .number_i      (number_i),
    .digit_count_i (digit_count_i),
    .start_line_i  (start_line_i),
    .start_column_i(start_column_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .out_line_o    (out_line_o),
    .out_column_o  (out_column_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Drop ready on the character port at random with a 29 percent chance, never while steady
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each character transaction; values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      digits_sb.check_char(char_code_o, out_line_o, out_column_o, last_o);
    end
  end

  // Present one number, hold it until the handshake completes, then record it.
  // An optional run of idle cycles comes first; valid drops only in those.
  task automatic send_number(fln2a_pkg::mode_e mode, logic [31:0] number, logic [5:0] count,
                             logic [2:0] line, logic [4:0] column);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= mode;
    number_i       <= number;
    digit_count_i  <= count;
    start_line_i   <= line;
    start_column_i <= column;
    do @(posedge clk_i); while (!in_ready_o);
    digits_sb.note_number(mode, number, count, line, column);
  endtask

  // Extremes of every field, every mode and each corner named for the formatter
  task automatic run_directed();
    send_number(fln2a_pkg::MODE_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd1, 5'd1);
    send_number(fln2a_pkg::MODE_UDEC, 32'd0,         6'd1,  3'd1, 5'd1);
    // digits beyond the native decimal width come out as zero
    send_number(fln2a_pkg::MODE_UDEC, 32'd1234567890, 6'd14, 3'd2, 5'd3);
    send_number(fln2a_pkg::MODE_UDEC, 32'd987654321, 6'd3,  3'd3, 5'd5);
    // most negative value: minus sign and full magnitude
    send_number(fln2a_pkg::MODE_SDEC, 32'h8000_0000, 6'd10, 3'd1, 5'd1);
    // zero in signed mode takes a plus sign
    send_number(fln2a_pkg::MODE_SDEC, 32'd0,         6'd4,  3'd2, 5'd2);
    send_number(fln2a_pkg::MODE_SDEC, 32'h7FFF_FFFF, 6'd10, 3'd3, 5'd4);
    send_number(fln2a_pkg::MODE_SDEC, 32'hFFFF_FFFF, 6'd2,  3'd4, 5'd6);
    // empty count: sign alone in signed mode, nothing otherwise
    send_number(fln2a_pkg::MODE_SDEC, 32'd12345,     6'd0,  3'd1, 5'd9);
    send_number(fln2a_pkg::MODE_UDEC, 32'd5,         6'd0,  3'd2, 5'd9);
    send_number(fln2a_pkg::MODE_HEX,  32'hDEAD_BEEF, 6'd8,  3'd1, 5'd1);
    send_number(fln2a_pkg::MODE_HEX,  32'hABCD_EF01, 6'd12, 3'd2, 5'd2);
    send_number(fln2a_pkg::MODE_HEX,  32'd0,         6'd0,  3'd3, 5'd3);
    send_number(fln2a_pkg::MODE_BIN,  32'hAAAA_AAAA, 6'd32, 3'd1, 5'd1);
    // counts above the maximum saturate
    send_number(fln2a_pkg::MODE_BIN,  32'h5555_5555, 6'd63, 3'd2, 5'd1);
    send_number(fln2a_pkg::MODE_BIN,  32'hFFFF_FFFF, 6'd33, 3'd3, 5'd1);
    // out-of-range line and column pass through
    send_number(fln2a_pkg::MODE_UDEC, 32'd42,        6'd63, 3'd7, 5'd31);
    send_number(fln2a_pkg::MODE_SDEC, -32'sd7,       6'd32, 3'd0, 5'd31);
    send_number(fln2a_pkg::MODE_HEX,  32'h1234_5678, 6'd40, 3'd4, 5'd16);
    send_number(fln2a_pkg::MODE_UDEC, 32'h8000_0000, 6'd10, 3'd2, 5'd0);
    send_number(fln2a_pkg::MODE_BIN,  32'd0,         6'd0,  3'd1, 5'd0);
    send_number(fln2a_pkg::MODE_HEX,  32'hFFFF_FFFF, 6'd1,  3'd4, 5'd16);
  endtask

  // Random numbers, mostly short runs so that the test stays quick
  task automatic run_random();
    logic [31:0] number;
    logic [5:0]  count;
    int unsigned pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // hold a stretch with no idling on either side
      steady = (i >= 30 && i < 60);
      pick = $urandom_range(99);
      if (pick < 40)      number = $urandom;
      else if (pick < 65) number = $urandom_range(0, 999);
      else if (pick < 80) number = -$urandom_range(1, 999);
      else if (pick < 90) number = 32'h7FFF_FFF0 + $urandom_range(0, 31);
      else                number = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      pick = $urandom_range(99);
      if (pick < 70)      count = 6'($urandom_range(1, 12));
      else if (pick < 85) count = 6'($urandom_range(13, 32));
      else                count = 6'($urandom_range(0, 63));
      send_number(fln2a_pkg::mode_e'($urandom_range(3)), number, count,
                  3'($urandom_range(7)), 5'($urandom_range(31)));
    end
    steady = 1'b0;
  endtask

  initial begin
    steady         = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = fln2a_pkg::MODE_UDEC;
    number_i       = '0;
    digit_count_i  = '0;
    start_line_i   = '0;
    start_column_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    // drain: wait for every owed character, then watch for stray ones
    while (digits_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (digits_sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Drop the run if the block hangs
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
